/* sv/uv_sphere_vertex_generator_top_macros.svh */
// assertion macros for the uv sphere vertex generator
`ifndef UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_TOP_MACROS_SVH

// clocked assertion with explicit clock and active-low reset
`define SVSG_ASSERT_CR(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same on the block clock and reset
`define SVSG_ASSERT(lbl, prop, msg) `SVSG_ASSERT_CR(lbl, clk_i, rst_ni, prop, msg)

`endif

/* sv/svsg_pkg.sv */
// shared types, constants and tables of the uv sphere vertex generator
`timescale 1ns / 1ps
package svsg_pkg;

  localparam int unsigned SUB_W              = 8;
  localparam int unsigned MAX_SUBDIVISIONS_D = 255;
  localparam int unsigned CORDIC_STEPS_D     = 16;
  localparam int unsigned DIV_STEPS          = 33;
  localparam int unsigned TDATA_W            = 200;
  localparam int unsigned ADDR_W             = 5;

  localparam logic [2:0] REG_RADIUS = 3'd0;
  localparam logic [2:0] REG_CX     = 3'd1;
  localparam logic [2:0] REG_CY     = 3'd2;
  localparam logic [2:0] REG_CZ     = 3'd3;
  localparam logic [2:0] REG_SUBDIV = 3'd4;

  localparam logic [30:0] RADIUS_RST = 31'd65536;
  localparam logic [7:0]  SUBDIV_RST = 8'd16;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;

  // result word bit positions
  localparam int unsigned POS_QV  = 192;
  localparam int unsigned POS_OOR = 193;

  typedef struct packed {
    logic [7:0] ring;
    logic [7:0] seg;
    logic       oor;
    logic       qv;
  } tag_t;

  typedef struct packed {
    logic [8:0]  rp;
    logic [8:0]  ra;
    logic [31:0] qp;
    logic [31:0] qa;
  } div_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [32:0] z;
    logic               flip;
  } rot_t;

  // arctangent of 2^-k in turn units (2^32 per turn)
  function automatic logic [29:0] atan_turn(input int unsigned k);
    logic [29:0] v;
    case (k)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10680862;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/svsg_div_cell.sv */
// one restoring division step for the polar and azimuth angles
`timescale 1ns / 1ps
module svsg_div_cell #(
  parameter int unsigned BIT_POS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  svsg_pkg::tag_t     tag_i,
  input  svsg_pkg::div_t     div_i,
  input  logic [7:0]         n_i,
  output logic               valid_o,
  output svsg_pkg::tag_t     tag_o,
  output svsg_pkg::div_t     div_o
);
  import svsg_pkg::*;

  logic       bp, ba;
  logic [9:0] dv, tp, ta, sp, sa;
  logic       gp, ga;
  logic       valid_q;
  tag_t       tag_q;
  div_t       div_q, div_d;

  // numerator bits: polar is j*2^32 + n, azimuth is i*2^33 + n
  if (BIT_POS == 32) begin : g_top
    assign bp = tag_i.ring[0];
    assign ba = 1'b0;
  end else if (BIT_POS < SUB_W) begin : g_low
    assign bp = n_i[BIT_POS];
    assign ba = n_i[BIT_POS];
  end else begin : g_mid
    assign bp = 1'b0;
    assign ba = 1'b0;
  end

  assign dv = {1'b0, n_i, 1'b0};
  assign tp = {div_i.rp, bp};
  assign ta = {div_i.ra, ba};
  assign gp = (tp >= dv);
  assign ga = (ta >= dv);
  assign sp = tp - dv;
  assign sa = ta - dv;

  always_comb begin
    div_d.rp = gp ? sp[8:0] : tp[8:0];
    div_d.ra = ga ? sa[8:0] : ta[8:0];
    div_d.qp = {div_i.qp[30:0], gp};
    div_d.qa = {div_i.qa[30:0], ga};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign div_o   = div_q;
endmodule

/* sv/svsg_cordic_cell.sv */
// one cordic rotation step on both angles
`timescale 1ns / 1ps
module svsg_cordic_cell #(
  parameter int unsigned K = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  svsg_pkg::tag_t tag_i,
  input  svsg_pkg::rot_t p_i,
  input  svsg_pkg::rot_t a_i,
  output logic           valid_o,
  output svsg_pkg::tag_t tag_o,
  output svsg_pkg::rot_t p_o,
  output svsg_pkg::rot_t a_o
);
  import svsg_pkg::*;

  logic valid_q;
  tag_t tag_q;
  rot_t p_q, a_q;

  function automatic rot_t rot_step(input rot_t r);
    rot_t               o;
    logic signed [32:0] dx, dy, at;
    dx = r.y >>> K;
    dy = r.x >>> K;
    at = 33'(atan_turn(K));
    o  = r;
    if (!r.z[32]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - at;
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + at;
    end
    return o;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q <= tag_i;
      p_q   <= rot_step(p_i);
      a_q   <= rot_step(a_i);
    end
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign p_o     = p_q;
  assign a_o     = a_q;
endmodule

/* sv/svsg_place.sv */
// products with the radius, offset from the center, triangle indices, result register
`timescale 1ns / 1ps
module svsg_place (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  svsg_pkg::tag_t                tag_i,
  input  svsg_pkg::rot_t                p_i,
  input  svsg_pkg::rot_t                a_i,
  input  logic [30:0]                   radius_i,
  input  logic signed [31:0]            cx_i,
  input  logic signed [31:0]            cy_i,
  input  logic signed [31:0]            cz_i,
  input  logic [7:0]                    n_i,
  output logic                          valid_o,
  output logic [svsg_pkg::TDATA_W-1:0]  tdata_o
);
  import svsg_pkg::*;

  localparam int unsigned NST = 6;

  logic [NST-1:0]     vld_q;
  tag_t               tag_q [NST];
  logic signed [31:0] sp_q, cp0_q, sa_q, ca_q;
  logic signed [63:0] mx_q, mz_q;
  logic signed [31:0] cp1_q, cp2_q, dx_q, dz_q;
  logic signed [63:0] px_q, py_q, pz_q;
  logic signed [32:0] ox_q, oy_q, oz_q;
  logic [31:0]        vx_q, vy_q, vz_q;
  logic [15:0]        a0_q, a1_q, a2_q, b2_q;
  logic signed [63:0] rx_s, rz_s, sx_s, sy_s, sz_s;
  logic signed [31:0] rad_s;
  logic [15:0]        row, nxt, a0, a1;
  logic [8:0]         n1;

  function automatic logic signed [31:0] unit(input logic signed [32:0] v, input logic f);
    logic signed [33:0] w;
    w = v;
    if (f) w = -w;
    if (w > 34'sd1073741824) return 32'sd1073741824;
    if (w < -34'sd1073741824) return -32'sd1073741824;
    return w[31:0];
  endfunction

  function automatic logic [31:0] place(input logic signed [31:0] c,
                                        input logic signed [32:0] o);
    logic signed [33:0] ce, oe, d;
    ce = c;
    oe = o;
    d  = ce - oe;
    if (d > 34'sd2147483647) return 32'h7fffffff;
    if (d < -34'sd2147483648) return 32'h80000000;
    return d[31:0];
  endfunction

  assign rad_s = $signed({1'b0, radius_i});
  assign rx_s  = mx_q + 64'sd536870912;
  assign rz_s  = mz_q + 64'sd536870912;
  assign sx_s  = px_q + 64'sd536870912;
  assign sy_s  = py_q + 64'sd536870912;
  assign sz_s  = pz_q + 64'sd536870912;

  assign n1  = {1'b0, n_i} + 9'd1;
  assign row = 16'(n1 * tag_q[4].ring);
  assign nxt = row + 16'(n1);
  assign a0  = 16'(tag_q[4].seg) + row;
  assign a1  = 16'(tag_q[4].seg) + nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < NST; s++) tag_q[s] <= tag_q[s-1];
      sp_q  <= unit(p_i.y, p_i.flip);
      cp0_q <= unit(p_i.x, p_i.flip);
      sa_q  <= unit(a_i.y, a_i.flip);
      ca_q  <= unit(a_i.x, a_i.flip);
      mx_q  <= sp_q * ca_q;
      mz_q  <= sp_q * sa_q;
      cp1_q <= cp0_q;
      dx_q  <= rx_s[61:30];
      dz_q  <= rz_s[61:30];
      cp2_q <= cp1_q;
      px_q  <= rad_s * dx_q;
      py_q  <= rad_s * cp2_q;
      pz_q  <= rad_s * dz_q;
      ox_q  <= sx_s[62:30];
      oy_q  <= sy_s[62:30];
      oz_q  <= sz_s[62:30];
      // out-of-range points give zeros, points on the last row or column no quad
      vx_q  <= tag_q[4].oor ? 32'd0 : place(cx_i, ox_q);
      vy_q  <= tag_q[4].oor ? 32'd0 : place(cy_i, oy_q);
      vz_q  <= tag_q[4].oor ? 32'd0 : place(cz_i, oz_q);
      a0_q  <= tag_q[4].qv ? a0 : 16'd0;
      a1_q  <= tag_q[4].qv ? a1 : 16'd0;
      a2_q  <= tag_q[4].qv ? a0 + 16'd1 : 16'd0;
      b2_q  <= tag_q[4].qv ? a1 + 16'd1 : 16'd0;
    end
  end

  assign valid_o = vld_q[NST-1];
  assign tdata_o = {6'd0, tag_q[5].oor, tag_q[5].qv, b2_q, a2_q, a1_q, a2_q, a1_q, a0_q,
                    vz_q, vy_q, vx_q};
endmodule

/* sv/uv_sphere_vertex_generator_top.sv */
// path: 33 divider cells, CORDIC_STEPS cordic cells (16 by default) and 6 output
//   stages from request to result
// throughput: one grid point per cycle; the whole chain holds while a result
//   waits in the output register and is not taken
// reset: asynchronous active low, clears all valid bits and loads the register
//   defaults (radius 1.0, center 0, 16 subdivisions); no clearing pass
`timescale 1ns / 1ps
`include "uv_sphere_vertex_generator_top_macros.svh"
module uv_sphere_vertex_generator_top #(
  parameter int unsigned MAX_SUBDIVISIONS = svsg_pkg::MAX_SUBDIVISIONS_D,
  parameter int unsigned CORDIC_STEPS     = svsg_pkg::CORDIC_STEPS_D
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // apb configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [svsg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input requests
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // ring_index, segment_index
  // results
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // vertex_x, vertex_y, vertex_z, tri_a0, tri_a1, tri_a2, tri_b0, tri_b1, tri_b2,
  // quad_valid, out_of_range, zero pad
  output logic [svsg_pkg::TDATA_W-1:0] m_axis_tdata
);
  import svsg_pkg::*;

  logic [30:0]        radius_q;
  logic signed [31:0] cx_q, cy_q, cz_q;
  logic [7:0]         subdiv_q, n_eff;
  logic               wr, adv;
  logic [7:0]         ring, seg;

  logic [DIV_STEPS:0]    div_vld;
  tag_t                  div_tag [DIV_STEPS+1];
  div_t                  div_dat [DIV_STEPS+1];
  logic [CORDIC_STEPS:0] cor_vld;
  tag_t                  cor_tag [CORDIC_STEPS+1];
  rot_t                  cor_p   [CORDIC_STEPS+1];
  rot_t                  cor_a   [CORDIC_STEPS+1];
  logic [31:0]           qp, qa;
  logic                  fp, fa;

  // register port
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      cx_q     <= '0;
      cy_q     <= '0;
      cz_q     <= '0;
      subdiv_q <= SUBDIV_RST;
    end else if (wr) begin
      case (paddr[4:2])
        REG_RADIUS: radius_q <= pwdata[30:0];
        REG_CX:     cx_q     <= pwdata;
        REG_CY:     cy_q     <= pwdata;
        REG_CZ:     cz_q     <= pwdata;
        REG_SUBDIV: subdiv_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_RADIUS: prdata = {1'b0, radius_q};
      REG_CX:     prdata = cx_q;
      REG_CY:     prdata = cy_q;
      REG_CZ:     prdata = cz_q;
      REG_SUBDIV: prdata = {24'd0, subdiv_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (subdiv_q == 8'd0) n_eff = 8'd1;
    else if (subdiv_q > 8'(MAX_SUBDIVISIONS)) n_eff = 8'(MAX_SUBDIVISIONS);
    else n_eff = subdiv_q;
  end

  // the chain moves whenever the output register is free or being emptied
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  assign ring = s_axis_tdata[7:0];
  assign seg  = s_axis_tdata[15:8];

  always_comb begin
    div_vld[0]      = s_axis_tvalid;
    div_tag[0].ring = ring;
    div_tag[0].seg  = seg;
    div_tag[0].oor  = (ring > n_eff) || (seg > n_eff);
    div_tag[0].qv   = (ring < n_eff) && (seg < n_eff);
    div_dat[0].rp   = {2'd0, ring[7:1]};
    div_dat[0].ra   = {1'b0, seg};
    div_dat[0].qp   = '0;
    div_dat[0].qa   = '0;
  end

  for (genvar c = 0; c < DIV_STEPS; c++) begin : g_div
    svsg_div_cell #(.BIT_POS(DIV_STEPS - 1 - c)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (div_vld[c]),
      .tag_i   (div_tag[c]),
      .div_i   (div_dat[c]),
      .n_i     (n_eff),
      .valid_o (div_vld[c+1]),
      .tag_o   (div_tag[c+1]),
      .div_o   (div_dat[c+1])
    );
  end

  // fold the angle into the right half-plane, remember the sign flip
  assign qp = div_dat[DIV_STEPS].qp;
  assign qa = div_dat[DIV_STEPS].qa;
  assign fp = qp[31] ^ qp[30];
  assign fa = qa[31] ^ qa[30];

  always_comb begin
    cor_vld[0]   = div_vld[DIV_STEPS];
    cor_tag[0]   = div_tag[DIV_STEPS];
    cor_p[0].x   = GAIN_Q30;
    cor_p[0].y   = '0;
    cor_p[0].z   = {qp[30], qp[30], qp[30:0]};
    cor_p[0].flip = fp;
    cor_a[0].x   = GAIN_Q30;
    cor_a[0].y   = '0;
    cor_a[0].z   = {qa[30], qa[30], qa[30:0]};
    cor_a[0].flip = fa;
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
    svsg_cordic_cell #(.K(k)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (cor_vld[k]),
      .tag_i   (cor_tag[k]),
      .p_i     (cor_p[k]),
      .a_i     (cor_a[k]),
      .valid_o (cor_vld[k+1]),
      .tag_o   (cor_tag[k+1]),
      .p_o     (cor_p[k+1]),
      .a_o     (cor_a[k+1])
    );
  end

  svsg_place u_place (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (cor_vld[CORDIC_STEPS]),
    .tag_i    (cor_tag[CORDIC_STEPS]),
    .p_i      (cor_p[CORDIC_STEPS]),
    .a_i      (cor_a[CORDIC_STEPS]),
    .radius_i (radius_q),
    .cx_i     (cx_q),
    .cy_i     (cy_q),
    .cz_i     (cz_q),
    .n_i      (n_eff),
    .valid_o  (m_axis_tvalid),
    .tdata_o  (m_axis_tdata)
  );

  `SVSG_ASSERT(a_accept_enters, s_axis_tvalid && s_axis_tready |=> div_vld[1], "accepted request did not enter the divider chain")
  `SVSG_ASSERT(a_stall_freezes, !adv |=> $stable(div_vld[DIV_STEPS:1]) && $stable(cor_vld), "chain moved while stalled")
  `SVSG_ASSERT(a_oor_zero, m_axis_tvalid && m_axis_tdata[POS_OOR] |-> !m_axis_tdata[POS_QV] && m_axis_tdata[95:0] == 96'd0, "out-of-range result not cleared")
endmodule
